// ----- hw/rtl/tsiq_pkg.sv -----
// ----------------------------------------------------------------------------
// tsiq_pkg: shared types and codes for the time sorted insert queue
// Entry layout, result bundle, op and status codes.
// ----------------------------------------------------------------------------
package tsiq_pkg;

    localparam int KEY_W = 11;
    localparam int TAG_W = 16;
    localparam int STATUS_W = 2;
    localparam int OCC_W = 7;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    key;
        logic [TAG_W-1:0]    tag;
        logic [OCC_W-1:0]    occ;
    } res_t;

endpackage

// ----- hw/rtl/time_sorted_insert_queue_top.sv -----
// ----------------------------------------------------------------------------
// time_sorted_insert_queue_top: sorted insertion queue of departure entries
// Insert walks down from the tail, one read and one compare per entry, moving each
// larger entry up one slot, then writes the new entry. Pop reads the head slot; a full
// insert or an empty pop goes straight to the result. One item at a time: the next
// item is taken in the cycle after the result enters the output register.
// Reset (async, rst_n low) empties the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module time_sorted_insert_queue_top #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  logic [tsiq_pkg::KEY_W-1:0]    departure_minutes,
    input  logic [tsiq_pkg::TAG_W-1:0]    flight_tag,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tsiq_pkg::STATUS_W-1:0] status,
    output logic [tsiq_pkg::KEY_W-1:0]    popped_minutes,
    output logic [tsiq_pkg::TAG_W-1:0]    popped_tag,
    output logic [tsiq_pkg::OCC_W-1:0]    occupancy
);
    import tsiq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic             res_valid;
    logic             res_ready;
    res_t             res;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    logic             out_valid_reg, out_valid_next;
    res_t             out_reg;

    tsiq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .op                (op),
        .departure_minutes (departure_minutes),
        .flight_tag        (flight_tag),
        .res_valid         (res_valid),
        .res_ready         (res_ready),
        .res               (res),
        .rd_en             (rd_en),
        .rd_addr           (rd_addr),
        .rd_data           (rd_data),
        .wr_en             (wr_en),
        .wr_addr           (wr_addr),
        .wr_data           (wr_data)
    );

    tsiq_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // output register frees the sequencer while a result waits
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_reg.status;
    assign popped_minutes = out_reg.key;
    assign popped_tag     = out_reg.tag;
    assign occupancy      = out_reg.occ;

endmodule

// ----- hw/rtl/tsiq_store.sv -----
// ----------------------------------------------------------------------------
// tsiq_store: entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tsiq_store #(
    parameter int QUEUE_DEPTH = 64,
    parameter int IDX_W = $clog2(QUEUE_DEPTH)
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output tsiq_pkg::entry_t rd_data,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  tsiq_pkg::entry_t wr_data
);
    import tsiq_pkg::*;

    entry_t mem [QUEUE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/tsiq_ctrl.sv -----
// ----------------------------------------------------------------------------
// tsiq_ctrl: queue sequencer
// Walks the ring from the tail, one compare per entry, moving larger entries
// up one slot until the insert point is found. Pops read the head slot.
// ----------------------------------------------------------------------------
module tsiq_ctrl #(
    parameter int QUEUE_DEPTH = 64,
    parameter int IDX_W = $clog2(QUEUE_DEPTH),
    parameter int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   op,
    input  logic [tsiq_pkg::KEY_W-1:0] departure_minutes,
    input  logic [tsiq_pkg::TAG_W-1:0] flight_tag,
    output logic                   res_valid,
    input  logic                   res_ready,
    output tsiq_pkg::res_t         res,
    output logic                   rd_en,
    output logic [IDX_W-1:0]       rd_addr,
    input  tsiq_pkg::entry_t       rd_data,
    output logic                   wr_en,
    output logic [IDX_W-1:0]       wr_addr,
    output tsiq_pkg::entry_t       wr_data
);
    import tsiq_pkg::*;

    localparam int SUM_W = IDX_W + 1;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_INS_RD   = 7'b0000010,
        S_INS_CMP  = 7'b0000100,
        S_INS_WR   = 7'b0001000,
        S_POP_RD   = 7'b0010000,
        S_POP_DATA = 7'b0100000,
        S_FIN      = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [TAG_W-1:0] tag_reg, tag_next;
    res_t             res_reg, res_next;

    logic [CNT_W-1:0] idx_prev;
    logic [IDX_W-1:0] slot_cur;
    logic [IDX_W-1:0] slot_prev;
    logic [IDX_W-1:0] head_inc;
    logic             full;

    // ring slot of a position: head + pos, wrapped once
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] pos);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(pos);
        if (sum >= SUM_W'(QUEUE_DEPTH))
        begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign idx_prev  = idx_reg - CNT_W'(1);
    assign slot_cur  = slot_of(head_reg, idx_reg);
    assign slot_prev = slot_of(head_reg, idx_prev);
    assign head_inc  = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_FIN);
    assign res       = res_reg;

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        key_next   = key_reg;
        tag_next   = tag_reg;
        res_next   = res_reg;
        rd_en      = 1'b0;
        rd_addr    = slot_prev;
        wr_en      = 1'b0;
        wr_addr    = slot_cur;
        wr_data    = rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next = departure_minutes;
                    tag_next = flight_tag;
                    idx_next = count_reg;
                    res_next.status = ST_DONE;
                    res_next.key    = '0;
                    res_next.tag    = '0;
                    res_next.occ    = OCC_W'(count_reg);
                    if (op == OP_INSERT)
                    begin
                        if (full)
                        begin
                            res_next.status = ST_FULL;
                            state_next      = S_FIN;
                        end
                        else if (count_reg == '0)
                        begin
                            state_next = S_INS_WR;
                        end
                        else
                        begin
                            state_next = S_INS_RD;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_next.status = ST_EMPTY;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            state_next = S_POP_RD;
                        end
                    end
                end
            end
            S_INS_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_INS_CMP;
            end
            S_INS_CMP:
            begin
                // strictly greater moves up; equal keys keep arrival order
                if (rd_data.key > key_reg)
                begin
                    wr_en    = 1'b1;
                    idx_next = idx_prev;
                    if (idx_prev == '0)
                    begin
                        state_next = S_INS_WR;
                    end
                    else
                    begin
                        state_next = S_INS_RD;
                    end
                end
                else
                begin
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                wr_en       = 1'b1;
                wr_data.key = key_reg;
                wr_data.tag = tag_reg;
                count_next  = count_reg + CNT_W'(1);
                res_next.occ = OCC_W'(count_next);
                state_next  = S_FIN;
            end
            S_POP_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = head_reg;
                state_next = S_POP_DATA;
            end
            S_POP_DATA:
            begin
                res_next.key = rd_data.key;
                res_next.tag = rd_data.tag;
                count_next   = count_reg - CNT_W'(1);
                head_next    = (count_next == '0) ? '0 : head_inc;
                res_next.occ = OCC_W'(count_next);
                state_next   = S_FIN;
            end
            S_FIN:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
        res_reg <= res_next;
    end

endmodule

// ----- tb/time_sorted_insert_queue_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// time_sorted_insert_queue_top_tb: self-checking bench for the sorted queue
// Sends inserts and pops over the valid/ready input with random gaps on both
// channels. A sorted list model of the departure schedule predicts every
// result, and each result field is compared against it in arrival order.
// ----------------------------------------------------------------------------
module time_sorted_insert_queue_top_tb;
    import tsiq_pkg::*;

    localparam int DEPTH       = 64;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 40;
    localparam int SETTLE      = 2 * DEPTH + 8;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                op;
    logic [KEY_W-1:0]    departure_minutes;
    logic [TAG_W-1:0]    flight_tag;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    popped_minutes;
    logic [TAG_W-1:0]    popped_tag;
    logic [OCC_W-1:0]    occupancy;

    entry_t schedule[$];      // departures held, ascending key, ties in arrival order
    res_t   pending[$];       // results still owed by the block
    int     err_count = 0;
    int     cycle_count = 0;
    bit     steady_flow = 1'b0;
    int     hold_token = 0;
    int     hold_left = 0;
    int     hold_seen = 0;
    int     gap_left = 0;

    time_sorted_insert_queue_top #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .op(op),
        .departure_minutes(departure_minutes),
        .flight_tag(flight_tag),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .popped_minutes(popped_minutes),
        .popped_tag(popped_tag),
        .occupancy(occupancy)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        if (err_count < MAX_REPORTS)
            $display("%0t: %s mismatch, expected 0x%0h got 0x%0h", $time, what, want, got);
        err_count++;
    endtask

    // Next result for one item; updates the schedule model.
    function automatic res_t schedule_step(input logic kind, input logic [KEY_W-1:0] key,
                                           input logic [TAG_W-1:0] tag);
        res_t   r;
        entry_t e;
        int     pos;
        r = '0;
        if (kind == OP_INSERT)
        begin
            if (schedule.size() >= DEPTH)
                r.status = ST_FULL;
            else
            begin
                pos = 0;
                while (pos < schedule.size() && schedule[pos].key <= key)
                    pos++;
                e.key = key;
                e.tag = tag;
                schedule.insert(pos, e);
            end
        end
        else if (schedule.size() == 0)
            r.status = ST_EMPTY;
        else
        begin
            e = schedule.pop_front();
            r.status = ST_DONE;
            r.key = e.key;
            r.tag = e.tag;
        end
        r.occ = OCC_W'(schedule.size());
        return r;
    endfunction

    // Results are checked before the item of the same edge is predicted.
    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending.size() == 0)
                    report_mismatch("unexpected result", 0, 32'(status));
                else
                begin
                    want = pending.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", 32'(want.status), 32'(status));
                    if (popped_minutes !== want.key)
                        report_mismatch("popped_minutes", 32'(want.key),
                                        32'(popped_minutes));
                    if (popped_tag !== want.tag)
                        report_mismatch("popped_tag", 32'(want.tag), 32'(popped_tag));
                    if (occupancy !== want.occ)
                        report_mismatch("occupancy", 32'(want.occ), 32'(occupancy));
                end
            end
            if (in_valid && in_ready)
                pending.push_back(schedule_step(op, departure_minutes, flight_tag));
        end
    end

    function automatic int next_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady_flow)
            return 0;
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Output side: random stalls, plus a long hold-off each time the token moves.
    always @(negedge clk)
    begin : result_sink
        if (hold_token != hold_seen)
        begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!steady_flow && $urandom_range(0, 3) == 0)
                gap_left = next_gap();
        end
    end

    task automatic send_item(input logic kind, input logic [KEY_W-1:0] key,
                             input logic [TAG_W-1:0] tag);
        int gap;
        gap = next_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= kind;
        departure_minutes <= key;
        flight_tag <= tag;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_pop();
        send_item(OP_POP, KEY_W'($urandom), TAG_W'($urandom));
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            return '0;
        if (roll < 7)
            return 11'd1439;
        if (roll < 10)
            return '1;
        if (roll < 40)
            return KEY_W'($urandom_range(500, 507));   // crowded keys force ties
        if (roll < 90)
            return KEY_W'($urandom_range(0, 1439));
        return KEY_W'($urandom_range(0, 2047));
    endfunction

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed_edges();
        send_pop();
        send_item(OP_INSERT, 11'd1439, 16'hFFFF);
        send_item(OP_INSERT, 11'd0, 16'h0000);
        send_item(OP_INSERT, 11'd1439, 16'h1234);
        send_item(OP_INSERT, 11'd2047, 16'hAAAA);
        send_item(OP_INSERT, 11'd0, 16'h5555);
        send_item(OP_INSERT, 11'd720, 16'h8001);
        send_item(OP_INSERT, 11'd1024, 16'h7FFE);
        send_item(OP_INSERT, 11'd1023, 16'h0001);
        repeat (8) send_pop();
        send_pop();
        send_item(OP_INSERT, 11'd1, 16'hC3C3);
        send_pop();
        wait_drained();
    endtask

    // Fill to the brim, overflow, then empty it past the bottom.
    task automatic test_fill_and_overflow();
        repeat (DEPTH) send_item(OP_INSERT, rand_key(), TAG_W'($urandom));
        send_item(OP_INSERT, 11'd0, 16'hFFFF);
        send_item(OP_INSERT, 11'd2047, 16'h0000);
        send_item(OP_INSERT, rand_key(), TAG_W'($urandom));
        send_pop();
        send_item(OP_INSERT, 11'd0, 16'h0F0F);
        send_item(OP_INSERT, 11'd1439, 16'hF0F0);
        repeat (DEPTH + 1) send_pop();
        wait_drained();
    endtask

    // Receiver holds off while items keep coming, so the input must stall.
    task automatic test_backpressure();
        steady_flow = 1'b1;
        hold_token++;
        repeat (12) send_item(OP_INSERT, rand_key(), TAG_W'($urandom));
        repeat (4) send_pop();
        steady_flow = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_mix();
        int phase;
        int insert_pct;
        for (phase = 0; phase < 12; phase++)
        begin
            case (phase % 3)
                0: insert_pct = 85;
                1: insert_pct = 25;
                default: insert_pct = 55;
            endcase
            steady_flow = (phase % 4 == 3);
            repeat (100)
            begin
                if ($urandom_range(1, 100) <= insert_pct)
                    send_item(OP_INSERT, rand_key(), TAG_W'($urandom));
                else
                    send_pop();
            end
            steady_flow = 1'b0;
            if (phase % 2 == 1)
                wait_drained();
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_INSERT;
        departure_minutes = '0;
        flight_tag = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_edges();
        test_fill_and_overflow();
        test_backpressure();
        test_random_mix();

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (pending.size() != 0)
            report_mismatch("results never delivered", pending.size(), 0);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
